// ===== rtl/jfn_pkg.sv =====
package jfn_pkg;

    localparam int WIN_CELLS = 125;
    localparam int NUM_OFFSETS = 27;
    localparam int CENTER_OFFSET = 13;
    localparam int CELL_IDX_W = 7;

    localparam logic [0:0] CFG_MODE_2D = 1'b0;
    localparam logic [0:0] CFG_ALLOW_DIAG = 1'b1;

    typedef logic signed [1:0] dir_t;

    typedef struct packed {
        logic [WIN_CELLS-1:0]   win;
        dir_t                   dir_x;
        dir_t                   dir_y;
        dir_t                   dir_z;
        logic [NUM_OFFSETS-1:0] elig;
    } dec_t;

    function automatic dir_t dir_norm(input logic [1:0] code);
        dir_t d;
        case (code)
            2'b00: d = 2'sd0;
            2'b01: d = 2'sd1;
            default: d = -2'sd1;
        endcase
        return d;
    endfunction

    function automatic int cell_index(input int dx, input int dy, input int dz);
        return (dz + 2) * 25 + (dy + 2) * 5 + (dx + 2);
    endfunction

    function automatic int back_step(input int o, input int d);
        return (o != 0 && d != 0) ? o - d : o;
    endfunction

    function automatic logic axis_ok(input int o, input int d);
        return (d == 0) ? (o == 0) : (o == 0 || o == d);
    endfunction

    function automatic logic offset_eligible(input int ox, input int oy, input int oz,
                                             input dir_t ux, input dir_t uy, input dir_t uz,
                                             input logic mode_2d, input logic allow_diag);
        int x;
        int y;
        int z;
        int n;
        logic ok;
        x = int'(ux);
        y = int'(uy);
        z = int'(uz);
        n = int'(ox != 0) + int'(oy != 0) + int'(oz != 0);
        ok = 1'b1;
        if (ox == x && oy == y && oz == z) ok = 1'b0;
        if (mode_2d && oz != 0) ok = 1'b0;
        if (!allow_diag && n != 1) ok = 1'b0;
        if (axis_ok(ox, x) && axis_ok(oy, y) && axis_ok(oz, z)) ok = 1'b0;
        if (!((ox != 0 && x != 0) || (oy != 0 && y != 0) || (oz != 0 && z != 0))) ok = 1'b0;
        return ok;
    endfunction

    function automatic logic [CELL_IDX_W-1:0] blocker_index(input int ox, input int oy,
                                                            input int oz, input dir_t ux,
                                                            input dir_t uy, input dir_t uz);
        return CELL_IDX_W'(cell_index(back_step(ox, int'(ux)), back_step(oy, int'(uy)),
                                      back_step(oz, int'(uz))));
    endfunction

endpackage

// ===== rtl/jps_forced_neighbor_check_3d_unit.sv =====
// Channel  Dir  Width  Contents
// s_axis   in   136    free_cells_low, free_cells_high, dir_x, dir_y, dir_z
// m_axis   out  8      forced
// cfg      in   1+1    mode_2d (index 0), diagonal enable (index 1)
//
// One transaction is taken per cycle unless a stall backs up to the first stage; each
// result passes three registers: direction decode, per-offset check, OR of the 26 checks.
// Reset is synchronous and active low; it empties the pipeline and loads the
// configuration defaults. A stall on the output holds each full stage whose next
// stage is full too, and lets empty stages fill, so nothing is dropped or repeated.
module jps_forced_neighbor_check_3d_unit import jfn_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // Bits from low: free_cells_low[63:0], free_cells_high[124:64], dir_x[126:125],
    // dir_y[128:127], dir_z[130:129], zero padding[135:131].
    input  logic [135:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // Bits from low: forced[0], zero padding[7:1].
    output logic [7:0]   m_tdata,
    input  logic         cfg_wr_en,
    input  logic [0:0]   cfg_index,
    input  logic [0:0]   cfg_data
);

    logic mode_2d_reg;
    logic allow_diag_reg;
    logic en1;
    logic en2;
    logic en3;
    logic v1;
    logic v2;
    logic v3;
    dec_t dec;
    logic [NUM_OFFSETS-1:0] hit;
    logic forced;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_2d_reg <= 1'b0;
            allow_diag_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MODE_2D: mode_2d_reg <= cfg_data[0];
                CFG_ALLOW_DIAG: allow_diag_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign en3 = !v3 || m_tready;
    assign en2 = !v2 || en3;
    assign en1 = !v1 || en2;
    assign s_tready = en1;

    jfn_decode u_decode (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load_en        (en1),
        .in_valid       (s_tvalid),
        .free_cells_low (s_tdata[63:0]),
        .free_cells_high(s_tdata[124:64]),
        .dir_x          (s_tdata[126:125]),
        .dir_y          (s_tdata[128:127]),
        .dir_z          (s_tdata[130:129]),
        .mode_2d        (mode_2d_reg),
        .diag_en        (allow_diag_reg),
        .valid_reg      (v1),
        .dec_reg        (dec)
    );

    jfn_eval u_eval (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load_en  (en2),
        .in_valid (v1),
        .dec      (dec),
        .valid_reg(v2),
        .hit_reg  (hit)
    );

    jfn_reduce u_reduce (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load_en   (en3),
        .in_valid  (v2),
        .hit       (hit),
        .valid_reg (v3),
        .forced_reg(forced)
    );

    assign m_tvalid = v3;
    assign m_tdata = {7'b0, forced};

    a_ready_when_out_empty: assert property (
        @(posedge aclk) disable iff (!aresetn) !m_tvalid |-> s_tready
    ) else $error("input not ready while the output register is empty");

    a_three_cycle_latency: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && m_tready) ##1 m_tready ##1 m_tready |=> m_tvalid
    ) else $error("result missing three cycles after an unstalled transaction");

    a_zero_dir_not_forced: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && m_tready && s_tdata[130:125] == 6'b0)
        ##1 m_tready ##1 m_tready |=> !m_tdata[0]
    ) else $error("zero direction reported a forced neighbor");

endmodule

// ===== rtl/jfn_decode.sv =====
module jfn_decode import jfn_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load_en,
    input  logic                 in_valid,
    input  logic [63:0]          free_cells_low,
    input  logic [60:0]          free_cells_high,
    input  logic [1:0]           dir_x,
    input  logic [1:0]           dir_y,
    input  logic [1:0]           dir_z,
    input  logic                 mode_2d,
    input  logic                 diag_en,
    output logic                 valid_reg,
    output dec_t                 dec_reg
);

    dec_t dec_next;
    logic valid_next;

    always_comb begin
        dec_next.win = {free_cells_high, free_cells_low};
        dec_next.dir_x = dir_norm(dir_x);
        dec_next.dir_y = dir_norm(dir_y);
        dec_next.dir_z = dir_norm(dir_z);
        for (int k = 0; k < NUM_OFFSETS; k++) begin
            if (k == CENTER_OFFSET) begin
                dec_next.elig[k] = 1'b0;
            end else begin
                dec_next.elig[k] = offset_eligible(k % 3 - 1, (k / 3) % 3 - 1, k / 9 - 1,
                                                   dec_next.dir_x, dec_next.dir_y,
                                                   dec_next.dir_z, mode_2d, diag_en);
            end
        end
    end

    assign valid_next = load_en ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_en && in_valid) begin
            dec_reg <= dec_next;
        end
    end

endmodule

// ===== rtl/jfn_eval.sv =====
module jfn_eval import jfn_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load_en,
    input  logic                   in_valid,
    input  dec_t                   dec,
    output logic                   valid_reg,
    output logic [NUM_OFFSETS-1:0] hit_reg
);

    logic [NUM_OFFSETS-1:0] hit_next;
    logic valid_next;

    for (genvar k = 0; k < NUM_OFFSETS; k++) begin : g_off
        localparam int OX = k % 3 - 1;
        localparam int OY = (k / 3) % 3 - 1;
        localparam int OZ = k / 9 - 1;
        localparam int CAND = cell_index(OX, OY, OZ);
        if (k == CENTER_OFFSET) begin : g_center
            assign hit_next[k] = 1'b0;
        end else begin : g_side
            logic [CELL_IDX_W-1:0] blk_idx;
            assign blk_idx = blocker_index(OX, OY, OZ, dec.dir_x, dec.dir_y, dec.dir_z);
            assign hit_next[k] = dec.elig[k] & dec.win[CAND] & ~dec.win[blk_idx];
        end
    end

    assign valid_next = load_en ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_en && in_valid) begin
            hit_reg <= hit_next;
        end
    end

endmodule

// ===== rtl/jfn_reduce.sv =====
module jfn_reduce import jfn_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load_en,
    input  logic                   in_valid,
    input  logic [NUM_OFFSETS-1:0] hit,
    output logic                   valid_reg,
    output logic                   forced_reg
);

    logic valid_next;
    logic forced_next;

    assign valid_next = load_en ? in_valid : valid_reg;
    assign forced_next = |hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_en && in_valid) begin
            forced_reg <= forced_next;
        end
    end

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import jfn_pkg::*;

    localparam int CYCLE_LIMIT = 100000;
    localparam int PHASE_QUERIES = 115;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AFTER = 200;

    typedef struct packed {
        logic [63:0] lo;
        logic [60:0] hi;
        dir_t        dx;
        dir_t        dy;
        dir_t        dz;
    } query_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [135:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [7:0]   m_tdata;
    logic         cfg_wr_en = 1'b0;
    logic [0:0]   cfg_index = '0;
    logic [0:0]   cfg_data = '0;

    query_t query_q[$];
    bit     forced_exp_q[$];
    query_t cur;
    bit     offering = 1'b0;
    bit     cfg_flat = 1'b0;
    bit     cfg_diag = 1'b1;
    bit     hold_off = 1'b0;
    int     burst_left = 0;
    int     gap_left = 0;
    int     accepted = 0;
    int     results = 0;
    int     forced_seen = 0;
    int     errors = 0;
    int     cyc = 0;
    int     rx_mode = 0;
    int     rx_left = 0;
    logic [15:0] stall_pat = '1;
    bit     want;
    bit     rdy;

    jps_forced_neighbor_check_3d_unit uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic int dir_val(input dir_t c);
        return (c == 2'sd0) ? 0 : (c == 2'sd1) ? 1 : -1;
    endfunction

    function automatic int win_bit(input int dx, input int dy, input int dz);
        return (dz + 2) * 25 + (dy + 2) * 5 + (dx + 2);
    endfunction

    function automatic bit along_dir(input int o, input int d);
        return (d == 0) ? (o == 0) : (o == 0 || o == d);
    endfunction

    function automatic bit has_forced(input query_t q, input bit flat, input bit diag);
        logic [124:0] win;
        int ux;
        int uy;
        int uz;
        int bx;
        int by;
        int bz;
        int n;
        bit hit;
        win = {q.hi, q.lo};
        ux = dir_val(q.dx);
        uy = dir_val(q.dy);
        uz = dir_val(q.dz);
        hit = 1'b0;
        for (int ox = -1; ox <= 1; ox++) begin
            for (int oy = -1; oy <= 1; oy++) begin
                for (int oz = -1; oz <= 1; oz++) begin
                    n = int'(ox != 0) + int'(oy != 0) + int'(oz != 0);
                    if (n == 0) continue;
                    if (ox == ux && oy == uy && oz == uz) continue;
                    if (flat && oz != 0) continue;
                    if (!diag && n != 1) continue;
                    if (along_dir(ox, ux) && along_dir(oy, uy) && along_dir(oz, uz)) continue;
                    if (!win[win_bit(ox, oy, oz)]) continue;
                    bx = (ox != 0 && ux != 0) ? ox - ux : ox;
                    by = (oy != 0 && uy != 0) ? oy - uy : oy;
                    bz = (oz != 0 && uz != 0) ? oz - uz : oz;
                    if (bx == ox && by == oy && bz == oz) continue;
                    if (!win[win_bit(bx, by, bz)]) hit = 1'b1;
                end
            end
        end
        return hit;
    endfunction

    function automatic query_t mk_query(input logic [124:0] win, input logic [1:0] cx,
                                        input logic [1:0] cy, input logic [1:0] cz);
        query_t q;
        q.lo = win[63:0];
        q.hi = win[124:64];
        q.dx = cx;
        q.dy = cy;
        q.dz = cz;
        return q;
    endfunction

    function automatic logic [124:0] rand_window(input int pct);
        logic [124:0] w;
        for (int j = 0; j < 125; j++) w[j] = ($urandom_range(0, 99) < pct);
        return w;
    endfunction

    function automatic logic [124:0] free_but(input int dx, input int dy, input int dz);
        logic [124:0] w;
        w = '1;
        w[win_bit(dx, dy, dz)] = 1'b0;
        return w;
    endfunction

    task automatic add_query(input query_t q);
        query_q.insert(query_q.size(), q);
    endtask

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 40) $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [0:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_MODE_2D) cfg_flat = val;
        else cfg_diag = val;
    endtask

    task automatic drain();
        while (query_q.size() != 0 || offering || forced_exp_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Sender: bursts of transactions separated by random gaps; valid holds until accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                forced_exp_q.insert(forced_exp_q.size(), has_forced(cur, cfg_flat, cfg_diag));
                accepted++;
                offering = 1'b0;
            end
            if (!offering) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (query_q.size() > 0) begin
                    cur = query_q.pop_front();
                    offering = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
            s_tvalid <= offering;
            s_tdata <= {5'b0, cur.dz, cur.dy, cur.dx, cur.hi, cur.lo};
        end
    end

    // Receiver: checks each result transaction and stalls in stretches of changing style.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results++;
            if (m_tdata[0]) forced_seen++;
            if (forced_exp_q.size() == 0) begin
                report_mismatch($sformatf("result forced=%0b with nothing expected", m_tdata[0]));
            end else begin
                want = forced_exp_q.pop_front();
                if (m_tdata[0] !== want)
                    report_mismatch($sformatf("result %0d: forced=%0b, expected %0b",
                                              results, m_tdata[0], want));
            end
        end
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(8, 80);
            stall_pat = 16'($urandom);
        end
        rx_left--;
        case (rx_mode)
            0: rdy = 1'b1;
            1: rdy = 1'($urandom_range(0, 1));
            default: begin
                rdy = stall_pat[0];
                stall_pat = {stall_pat[0], stall_pat[15:1]};
            end
        endcase
        m_tready <= !hold_off && rdy;
    end

    // Long back-pressure stretch in the middle of the run so the pipeline fills up.
    initial begin
        while (accepted < HOLD_AFTER) @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc == CYCLE_LIMIT) begin
            $display("** jps_forced_neighbor_check_3d_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        bit phase_flat[5];
        bit phase_diag[5];
        int pct;
        phase_flat = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
        phase_diag = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        add_query(mk_query('1, 2'b01, 2'b00, 2'b00));
        add_query(mk_query('0, 2'b01, 2'b00, 2'b00));
        add_query(mk_query(free_but(0, 1, 0), 2'b01, 2'b00, 2'b00));
        add_query(mk_query(free_but(-2, 0, 0), 2'b01, 2'b01, 2'b01));
        add_query(mk_query(free_but(0, -2, 0), 2'b00, 2'b01, 2'b01));
        add_query(mk_query(rand_window(50), 2'b00, 2'b00, 2'b00));
        add_query(mk_query(free_but(0, 1, 0), 2'b00, 2'b00, 2'b00));
        add_query(mk_query(free_but(0, 1, 0), 2'b10, 2'b00, 2'b00));
        add_query(mk_query(free_but(0, 1, 0), 2'b11, 2'b00, 2'b00));
        add_query(mk_query(free_but(1, 0, 0), 2'b00, 2'b10, 2'b11));
        add_query(mk_query({61'h0, 64'hFFFF_FFFF_FFFF_FFFF}, 2'b00, 2'b00, 2'b01));
        add_query(mk_query({61'h1FFF_FFFF_FFFF_FFFF, 64'h0}, 2'b00, 2'b00, 2'b11));
        add_query(mk_query({61'h0AAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555},
                           2'b01, 2'b11, 2'b00));
        add_query(mk_query({61'h1555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA},
                           2'b10, 2'b01, 2'b01));
        for (int i = 0; i < 10; i++)
            add_query(mk_query(rand_window((i % 2) ? 20 : 80), 2'(i), 2'(i + 1),
                               2'(i >> 1)));
        drain();

        for (int p = 0; p < 5; p++) begin
            write_reg(CFG_MODE_2D, phase_flat[p]);
            write_reg(CFG_ALLOW_DIAG, phase_diag[p]);
            for (int i = 0; i < PHASE_QUERIES; i++) begin
                case ($urandom_range(0, 3))
                    0: pct = $urandom_range(85, 100);
                    1: pct = $urandom_range(0, 15);
                    default: pct = $urandom_range(15, 85);
                endcase
                add_query(mk_query(rand_window(pct), 2'($urandom_range(0, 3)),
                                   2'($urandom_range(0, 3)), 2'($urandom_range(0, 3))));
            end
            drain();
        end

        repeat (8) @(posedge aclk);
        $display("Checked %0d window queries against %0d results, %0d of them forced,",
                 accepted, results, forced_seen);
        $display("across every 2D and diagonal register setting, with a %0d-cycle output hold.",
                 HOLD_CYCLES);
        if (errors == 0) begin
            $display("** jps_forced_neighbor_check_3d_unit: PASSED **");
        end else begin
            $display("** jps_forced_neighbor_check_3d_unit: FAILED **");
        end
        $finish;
    end

endmodule
